FILE: rtl/adpcm_pkg.sv
package adpcm_pkg;

   localparam int DATA_W  = 16;
   localparam int STEP_W  = 15;
   localparam int MAG_W   = 16;
   localparam int REM_W   = MAG_W + 2;
   localparam int PD_W    = STEP_W + 4;
   localparam int MULT_W  = 10;
   localparam int PS_W    = STEP_W + MULT_W;

   localparam logic [STEP_W-1:0] STEP_RESET = 15'd127;
   localparam logic [STEP_W-1:0] STEP_MIN   = 15'd127;
   localparam logic [STEP_W-1:0] STEP_MAX   = 15'd24576;
   localparam logic [STEP_W-1:0] DIFF_MAX   = 15'd32767;

   localparam logic signed [DATA_W-1:0] HIST_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] HIST_MIN = 16'sh8000;

   // history decay: h * 254 / 256, truncated toward zero
   localparam int DECAY_NUM   = 254;
   localparam int DECAY_SHIFT = 8;
   localparam int DECAY_BIAS  = (1 << DECAY_SHIFT) - 1;

   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MODE = '0;

   typedef enum logic {
      OP_ENC = 1'b0,
      OP_DEC = 1'b1
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic               restart;
      logic [DATA_W-1:0]  data;
      logic               last;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_MUL,
      ST_UPD
   } seq_state_type;

   function automatic logic [MULT_W-1:0] step_mult(input logic [2:0] mag);
      logic [MULT_W-1:0] m;
      case (mag)
         3'd0, 3'd1, 3'd2, 3'd3: m = 10'd230;
         3'd4:                   m = 10'd307;
         3'd5:                   m = 10'd409;
         3'd6:                   m = 10'd512;
         default:                m = 10'd614;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/adpcm_if.sv
interface adpcm_req_if;
   import adpcm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      restart;
   logic signed [DATA_W-1:0]  data_in;
   logic                      last_item;

   modport source (output valid, output restart, output data_in, output last_item,
                   input ready);
   modport sink   (input valid, input restart, input data_in, input last_item,
                   output ready);
endinterface

interface adpcm_rsp_if;
   import adpcm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  data_out;
   logic                      last_of_run;

   modport source (output valid, output data_out, output last_of_run, input ready);
   modport sink   (input valid, input data_out, input last_of_run, output ready);
endinterface

FILE: rtl/adpcm_front.sv
module adpcm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  adpcm_pkg::op_kind_type  mode,
   adpcm_req_if.sink               req,
   output adpcm_pkg::head_type     head,
   input  logic                    pop
);
   import adpcm_pkg::*;

   op_type             q_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               push;
   op_type             entry;

   assign req.ready = (cnt_ff != QCNT_W'(Q_DEPTH));
   assign push      = req.valid && req.ready;

   // request is tagged with the direction in force when it arrives
   assign entry.kind    = mode;
   assign entry.restart = req.restart;
   assign entry.data    = req.data_in;
   assign entry.last    = req.last_item;

   assign head.valid = (cnt_ff != '0);
   assign head.op    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: rtl/adpcm_back.sv
module adpcm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  adpcm_pkg::head_type  head,
   output logic                 pop,
   adpcm_rsp_if.source          rsp
);
   import adpcm_pkg::*;

   seq_state_type              state_ff, state_in;
   op_type                     op_ff, op_in;
   logic signed [DATA_W-1:0]   hist_ff, hist_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [2:0]                 q_ff, q_in;
   logic                       sat_ff, sat_in;
   logic                       sign_ff, sign_in;
   logic [3:0]                 code_ff, code_in;
   logic                       nib_ff, nib_in;
   logic [PD_W-1:0]            pd_ff, pd_in;
   logic [PS_W-1:0]            ps_ff, ps_in;
   logic signed [DATA_W-1:0]   hv_ff, hv_in;
   logic [3:0]                 pend_code_ff, pend_code_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]          out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;

   // intake: restart applied ahead of everything else
   logic signed [DATA_W-1:0]   hist_eff;
   logic [STEP_W-1:0]          step_eff;
   logic signed [DATA_W-1:0]   masked;
   logic signed [DATA_W:0]     diff;
   logic [MAG_W-1:0]           mag;
   // quotient, two bits a cycle
   logic [REM_W-1:0]           s8, s4, s2, s1, r1, r2;
   logic                       sat1, ge4, ge2, ge1;
   // step update
   logic [3:0]                 cur_code;
   logic [PD_W-1:0]            pd_prod;
   logic [PS_W-1:0]            ps_prod;
   logic signed [PS_W-1:0]     dec_prod, dec_bias;
   logic signed [DATA_W-1:0]   decayed;
   logic [DATA_W-1:0]          dv;
   logic [STEP_W-1:0]          dclip;
   logic signed [DATA_W:0]     nsum;
   logic signed [DATA_W-1:0]   nhist;
   logic [STEP_W+1:0]          nstep_raw;
   logic [STEP_W-1:0]          nstep;
   logic                       emit;
   logic [DATA_W-1:0]          emit_data;
   logic                       emit_last;
   logic                       upd_stall;

   assign hist_eff = head.op.restart ? '0 : hist_ff;
   assign step_eff = head.op.restart ? STEP_RESET : step_ff;
   assign masked   = $signed({head.op.data[DATA_W-1:3], 3'b000});
   assign diff     = (DATA_W+1)'(masked) - (DATA_W+1)'(hist_eff);
   assign mag      = diff[DATA_W] ? MAG_W'(-diff) : MAG_W'(diff);

   assign s8   = {step_ff, 3'b000};
   assign s4   = {1'b0, step_ff, 2'b00};
   assign s2   = {2'b00, step_ff, 1'b0};
   assign s1   = {3'b000, step_ff};
   assign sat1 = (rem_ff >= s8);
   assign ge4  = (rem_ff >= s4);
   assign r1   = ge4 ? rem_ff - s4 : rem_ff;
   assign ge2  = (rem_ff >= s2);
   assign r2   = ge2 ? rem_ff - s2 : rem_ff;
   assign ge1  = (r2 >= s1);

   assign cur_code = (op_ff.kind == OP_DEC)
                   ? (nib_ff ? op_ff.data[7:4] : op_ff.data[3:0])
                   : {sign_ff, q_ff};
   assign pd_prod  = PD_W'({cur_code[2:0], 1'b1}) * PD_W'(step_ff);
   assign ps_prod  = PS_W'(step_mult(cur_code[2:0])) * PS_W'(step_ff);
   assign dec_prod = PS_W'(hist_ff) * PS_W'(DECAY_NUM);
   assign dec_bias = dec_prod + (dec_prod[PS_W-1] ? PS_W'(DECAY_BIAS) : '0);
   assign decayed  = DATA_W'(dec_bias >>> DECAY_SHIFT);

   assign dv    = pd_ff[PD_W-1:3];
   assign dclip = (dv > DATA_W'(DIFF_MAX)) ? DIFF_MAX : dv[STEP_W-1:0];
   assign nsum  = code_ff[3] ? (DATA_W+1)'(hv_ff) - $signed({2'b00, dclip})
                             : (DATA_W+1)'(hv_ff) + $signed({2'b00, dclip});
   assign nhist = (nsum > (DATA_W+1)'(HIST_MAX)) ? HIST_MAX
                : (nsum < (DATA_W+1)'(HIST_MIN)) ? HIST_MIN
                : DATA_W'(nsum);
   assign nstep_raw = ps_ff[PS_W-1:8];
   assign nstep = (nstep_raw < (STEP_W+2)'(STEP_MIN)) ? STEP_MIN
                : (nstep_raw > (STEP_W+2)'(STEP_MAX)) ? STEP_MAX
                : nstep_raw[STEP_W-1:0];

   always_comb begin
      emit      = 1'b0;
      emit_data = '0;
      emit_last = 1'b1;
      if (op_ff.kind == OP_DEC) begin
         emit      = 1'b1;
         emit_data = nhist;
         emit_last = nib_ff;
      end else if (pend_valid_ff) begin
         emit      = 1'b1;
         emit_data = {8'h00, code_ff, pend_code_ff};
      end else if (op_ff.last) begin
         emit      = 1'b1;
         emit_data = {12'h000, code_ff};
      end
   end

   assign upd_stall = emit && out_valid_ff && !rsp.ready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      hist_in       = hist_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      sat_in        = sat_ff;
      sign_in       = sign_ff;
      code_in       = code_ff;
      nib_in        = nib_ff;
      pd_in         = pd_ff;
      ps_in         = ps_ff;
      hv_in         = hv_ff;
      pend_code_in  = pend_code_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      pop           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               op_in    = head.op;
               hist_in  = hist_eff;
               step_in  = step_eff;
               nib_in   = 1'b0;
               rem_in   = {mag, 2'b00};
               sign_in  = diff[DATA_W];
               state_in = (head.op.kind == OP_DEC) ? ST_MUL : ST_DIV1;
            end
         end
         ST_DIV1: begin
            sat_in   = sat1;
            q_in     = sat1 ? 3'd7 : {ge4, 2'b00};
            rem_in   = r1;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (!sat_ff) begin
               q_in = {q_ff[2], ge2, ge1};
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            code_in  = cur_code;
            pd_in    = pd_prod;
            ps_in    = ps_prod;
            hv_in    = (op_ff.kind == OP_DEC) ? decayed : hist_ff;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!upd_stall) begin
               hist_in = nhist;
               step_in = nstep;
               if (emit) begin
                  out_valid_in = 1'b1;
                  out_data_in  = emit_data;
                  out_last_in  = emit_last;
               end
               if (op_ff.kind == OP_ENC) begin
                  if (pend_valid_ff || op_ff.last) begin
                     pend_valid_in = 1'b0;
                     pend_code_in  = '0;
                  end else begin
                     pend_valid_in = 1'b1;
                     pend_code_in  = code_ff;
                  end
               end
               if (op_ff.kind == OP_DEC && !nib_ff) begin
                  nib_in   = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff       <= '0;
         step_ff       <= STEP_RESET;
         pend_code_ff  <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hist_ff       <= hist_in;
         step_ff       <= step_in;
         pend_code_ff  <= pend_code_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      sat_ff      <= sat_in;
      sign_ff     <= sign_in;
      code_ff     <= code_in;
      nib_ff      <= nib_in;
      pd_ff       <= pd_in;
      ps_ff       <= ps_in;
      hv_ff       <= hv_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.data_out    = $signed(out_data_ff);
   assign rsp.last_of_run = out_last_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff >= STEP_MIN && step_ff <= STEP_MAX)
      else $error("step size left its clamp range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && upd_stall) |=>
         (state_ff == ST_UPD && $stable(hist_ff) && $stable(pend_valid_ff)))
      else $error("state moved while result register was blocked");

   a_dec_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && !upd_stall && op_ff.kind == OP_DEC && !nib_ff) |=>
         (state_ff == ST_MUL && nib_ff))
      else $error("decode did not move on to the high nibble");

   a_sat_code: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2 && sat_ff) |=> (q_ff == 3'd7))
      else $error("saturated quotient lost");

endmodule

FILE: rtl/adpcm_4bit_codec_unit.sv
// Adaptive 4-bit ADPCM codec. The mode register (offset 0, bit 0) picks the
// direction: 0 encodes signed 16-bit samples into code bytes, 1 decodes code
// bytes (low 8 bits of data_in) into signed samples. Encoding packs two codes
// per byte, low nibble first; a request with last_item set and no pending
// half byte sends its code alone with a zero high nibble, so an encoded
// sample gives zero or one result. Each decoded byte always gives two
// samples, low nibble first, the second flagged last_of_run. restart clears
// history and resets the step size to 127 before the request; a pending half
// byte survives it and survives a mode change. Encoding runs two quotient
// states for the saturated 3-bit quotient (two restoring compare/subtract
// steps per cycle), then one for the step multiplies and one for the clamped
// update; decoding runs the decay/multiply and update states once per
// nibble. A 2-deep request queue lets requests land while the sequencer
// works, and a result register lets the sequencer finish while a result
// waits; it only halts at update when it has a result and that register
// is still full. Change mode only while the block is idle.
module adpcm_4bit_codec_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   adpcm_req_if.sink                            req,
   adpcm_rsp_if.source                          rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [adpcm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [adpcm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [adpcm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import adpcm_pkg::*;

   op_kind_type            mode_ff, mode_in;
   logic [CSR_IDX_W-1:0]   csr_idx;
   logic                   csr_wr;
   head_type               head;
   logic                   pop;

   // register select on word address; byte lanes ignored
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && csr_idx == CSR_IDX_MODE) begin
         mode_in = op_kind_type'(csr_pwdata[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= OP_ENC;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // reads of unmapped offsets return zero
   assign csr_prdata = (csr_idx == CSR_IDX_MODE)
                     ? {{(CSR_DATA_W-1){1'b0}}, mode_ff}
                     : '0;

   // front: takes requests, tags direction, queues them
   adpcm_front u_front (
      .clock (clock),
      .reset (reset),
      .mode  (mode_ff),
      .req   (req),
      .head  (head),
      .pop   (pop)
   );

   // back: quotient, step adaptation, packing, result register
   adpcm_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import adpcm_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
   } codec_word_type;

   // Predicts the codec's output and checks it in order.
   class codec_scoreboard;
      op_kind_type     mode;
      int              hist;
      int              step;
      logic [3:0]      held_code;
      logic            held;
      int              adapt_mult[8] = '{230, 230, 230, 230, 307, 409, 512, 614};
      codec_word_type  expected[$];
      int              errors;
      int              enc_reqs;
      int              dec_reqs;
      int              words_seen;

      function new();
         mode       = OP_ENC;
         hist       = 0;
         step       = 127;
         held_code  = '0;
         held       = 1'b0;
         errors     = 0;
         enc_reqs   = 0;
         dec_reqs   = 0;
         words_seen = 0;
      endfunction

      // shared step adaptation for one 4-bit code
      function void adapt_step(logic [3:0] code);
         int mag;
         int d;
         int ns;
         mag = int'(code[2:0]);
         d   = ((1 + 2 * mag) * step) >>> 3;
         ns  = (adapt_mult[mag] * step) >>> 8;
         if (d > 32767) d = 32767;
         hist = code[3] ? hist - d : hist + d;
         if (hist > 32767) hist = 32767;
         if (hist < -32768) hist = -32768;
         step = (ns > 24576) ? 24576 : ((ns < 127) ? 127 : ns);
      endfunction

      function void note_request(logic rs, logic [DATA_W-1:0] raw, logic lst);
         int         pcm;
         int         diff;
         int         mag;
         int         q;
         logic [3:0] code;
         logic [3:0] nib;
         if (rs) begin
            hist = 0;
            step = 127;
         end
         if (mode == OP_DEC) begin
            dec_reqs++;
            // two samples per byte, low nibble first; decay before each
            for (int k = 0; k < 2; k++) begin
               nib  = (k == 0) ? raw[3:0] : raw[7:4];
               hist = (hist * 254) / 256;
               adapt_step(nib);
               expected.push_back('{data: hist[DATA_W-1:0], last: (k == 1)});
            end
         end else begin
            enc_reqs++;
            pcm  = int'($signed(raw)) - int'(raw[2:0]);
            diff = pcm - hist;
            mag  = (diff < 0) ? -diff : diff;
            q    = (4 * mag) / step;
            code = (q > 7) ? 4'd7 : 4'(q);
            if (diff < 0) code[3] = 1'b1;
            if (held) begin
               expected.push_back('{data: {8'h00, code, held_code}, last: 1'b1});
               held      = 1'b0;
               held_code = '0;
            end else if (lst) begin
               // flush of a lone half byte
               expected.push_back('{data: {12'h000, code}, last: 1'b1});
            end else begin
               held_code = code;
               held      = 1'b1;
            end
            adapt_step(code);
         end
      endfunction

      function void check_result(logic [DATA_W-1:0] data, logic last);
         codec_word_type want;
         words_seen++;
         if (expected.size() == 0) begin
            errors++;
            $error("unexpected result: data_out 0x%04h last_of_run %0b", data, last);
            return;
         end
         want = expected.pop_front();
         if (data !== want.data) begin
            errors++;
            $error("data_out: expected 0x%04h, got 0x%04h", want.data, data);
         end
         if (last !== want.last) begin
            errors++;
            $error("last_of_run: expected %0b, got %0b", want.last, last);
         end
      endfunction
   endclass

   localparam int HALF_PERIOD    = 5;
   // request queue (2) + sequencer + result register, with margin
   localparam int SETTLE_CYCLES  = 24;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 125;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = {CSR_IDX_MODE, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   adpcm_req_if req_bus();
   adpcm_rsp_if rsp_bus();

   codec_scoreboard sb = new();

   // pacing knobs: percent of cycles each side sits idle
   int src_pct  = 0;
   int snk_pct  = 0;
   int rsp_hold = 0;
   int requests_sent = 0;
   int src_tbl[4] = '{0, 64, 0, 8};
   int snk_tbl[4] = '{0, 0, 64, 8};

   adpcm_4bit_codec_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // result side: random stalls, plus a long hold counted down here
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= snk_pct);
         end
      end
   end

   // both handshakes seen at the rising edge; results first, they can only
   // belong to earlier requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.data_out, rsp_bus.last_of_run);
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.restart, req_bus.data_in, req_bus.last_item);
      end
   end

   task automatic send_request(input logic rs, input logic [DATA_W-1:0] d,
                               input logic lst);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.restart   = rs;
      req_bus.data_in   = d;
      req_bus.last_item = lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
   endtask

   // stop offering, let every expected result come out, then keep waiting so
   // that a result-less encode request can clear the sequencer
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup + access write, then read back
   task automatic write_mode(input op_kind_type m);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = MODE_ADDR;
      csr_pwdata  = CSR_DATA_W'(m);
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.mode = m;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[0] !== m) begin
         sb.errors++;
         $error("mode: expected %0b, got %0b", m, csr_prdata[0]);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // PCM stream as a random walk with mixed jump sizes
   task automatic encode_stream(input int len);
      int   pcm;
      int   jump;
      logic rs;
      pcm = int'($signed(16'($urandom)));
      rs  = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 3))
            0: begin
               jump = int'($urandom_range(0, 256)) - 128;
            end
            1: begin
               jump = int'($urandom_range(0, 4096)) - 2048;
            end
            2: begin
               jump = int'($urandom_range(0, 32768)) - 16384;
            end
            default: begin
               jump = int'($signed(16'($urandom))) - pcm;
            end
         endcase
         pcm += jump;
         if (pcm > 32767) pcm = 32767;
         if (pcm < -32768) pcm = -32768;
         send_request(rs && k == 0, pcm[DATA_W-1:0], k == len - 1);
      end
   endtask

   // code bytes; upper bits and last_item are don't-care for the block
   task automatic decode_stream(input int len);
      logic rs;
      rs = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++)
         send_request(rs && k == 0, 16'($urandom), $urandom_range(0, 7) == 0);
   endtask

   initial begin
      int start;
      bit paused;
      req_bus.valid     = 1'b0;
      req_bus.restart   = 1'b0;
      req_bus.data_in   = '0;
      req_bus.last_item = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: encode extremes, masking, pairing, flush, restart mid-pair
      write_mode(OP_ENC);
      send_request(1'b1, 16'h0000, 1'b0);
      send_request(1'b0, 16'h7FFF, 1'b0);
      send_request(1'b0, 16'h8000, 1'b0);
      send_request(1'b1, 16'h7FFF, 1'b0);   // restart keeps the half byte
      send_request(1'b0, 16'h0007, 1'b1);   // lone code flushed
      send_request(1'b0, 16'hFFF8, 1'b0);
      send_request(1'b0, 16'hFFFF, 1'b1);   // last on the second code
      // full-swing square wave: step size and history hit their limits
      repeat (2) begin
         send_request(1'b0, 16'h7FFF, 1'b0);
         send_request(1'b0, 16'h8000, 1'b0);
      end
      send_request(1'b0, 16'h04D2, 1'b0);   // half byte left across the mode change
      drain_results();

      // directed decode: max positive codes, then negatives drive history to its clamp
      write_mode(OP_DEC);
      send_request(1'b1, 16'h0077, 1'b0);
      send_request(1'b0, 16'h0077, 1'b0);
      send_request(1'b0, 16'h0077, 1'b0);
      send_request(1'b0, 16'hAB8F, 1'b1);
      send_request(1'b0, 16'h0000, 1'b0);
      send_request(1'b0, 16'hFFFF, 1'b0);
      send_request(1'b0, 16'h0088, 1'b0);
      send_request(1'b1, 16'h00F0, 1'b0);
      drain_results();

      write_mode(OP_ENC);
      send_request(1'b0, 16'h1000, 1'b0);   // completes the waiting half byte
      send_request(1'b0, 16'hC000, 1'b1);
      drain_results();

      // random phases: alternate direction, walk through the pacing mixes
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_mode((phase % 2) ? OP_DEC : OP_ENC);
         src_pct = src_tbl[(phase / 2) % 4];
         snk_pct = snk_tbl[(phase / 2) % 4];
         if (phase == 1) rsp_hold = HOLD_CYCLES;   // back up the block
         start  = requests_sent;
         paused = 1'b0;
         while (requests_sent - start < PHASE_REQUESTS) begin
            if (phase == 4 && !paused && requests_sent - start >= PHASE_REQUESTS / 2) begin
               drain_results();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
               if (phase % 2)
                  decode_stream($urandom_range(1, 24));
               else
                  encode_stream($urandom_range(1, 24));
            end else begin
               send_request(1'($urandom_range(0, 1)), 16'($urandom),
                            1'($urandom_range(0, 1)));
            end
         end
         drain_results();
      end

      $display("Covered %0d encode and %0d decode requests, %0d results checked,",
               sb.enc_reqs, sb.dec_reqs, sb.words_seen);
      $display("both directions under four pacing mixes, a long output hold and a drain.");
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end
endmodule

FILE: files.f
rtl/adpcm_pkg.sv
rtl/adpcm_if.sv
rtl/adpcm_front.sv
rtl/adpcm_back.sv
rtl/adpcm_4bit_codec_unit.sv
dv/testbench.sv
